// ===== hdl/ssgh_pkg.sv =====
package ssgh_pkg;

	localparam int CmdWidth    = 3;
	localparam int RegWidth    = 24;
	localparam int PosWidth    = 32;
	localparam int IdxWidth    = 2;
	localparam int InDataWidth  = 56;
	localparam int OutDataWidth = 72;
	localparam int HomingChunk = 200;

	typedef enum logic [CmdWidth-1:0] {
		KIND_TICK     = 3'd0,
		KIND_MOVE     = 3'd1,
		KIND_STOP     = 3'd2,
		KIND_HOME     = 3'd3,
		KIND_OVERRIDE = 3'd4,
		KIND_ORIGIN   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_READY     = 2'd0,
		ST_DRIVING   = 2'd1,
		ST_HOMING    = 2'd2,
		ST_OVERLIMIT = 2'd3
	} status_t;

	typedef enum logic [IdxWidth-1:0] {
		REG_MAX_POSITION = 2'd0,
		REG_FAST_IVL     = 2'd1,
		REG_SLOW_IVL     = 2'd2,
		REG_BACKOFF      = 2'd3
	} reg_idx_t;

endpackage

// ===== hdl/stepper_step_generator_with_homing.sv =====
// Channel  | Signals                       | Content
// s_axis   | tvalid tready tdata tuser     | command: tuser = kind, tdata = move fields
// m_axis   | tvalid tready tdata           | one result per command
// cfg      | cfg_we cfg_index cfg_data     | register writes, no read-back
//
// One command per cycle while s_axis_tready is high; its result appears in the output register in the following cycle.
// All state update is one combinational pass from the state registers.
// s_axis_tready is high while the output register is empty or being taken.
// arst_n clears all state to its reset values and empties the output register.
module stepper_step_generator_with_homing #(
	parameter int LIMIT_MARGIN = 50,
	parameter int COUNT_WIDTH  = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [23:0] move_steps, [24] direction, [48:25] step_interval,
	// [49] limit_switch, [50] override_value, [55:51] zero
	input  logic [ssgh_pkg::InDataWidth-1:0]   s_axis_tdata,
	// [2:0] kind
	input  logic [ssgh_pkg::CmdWidth-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] step_level, [1] dir_level, [2] stepped, [4:3] status,
	// [36:5] abs_position, [68:37] work_position, [71:69] zero
	output logic [ssgh_pkg::OutDataWidth-1:0]  m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [ssgh_pkg::IdxWidth-1:0]      cfg_index,
	input  logic [ssgh_pkg::RegWidth-1:0]      cfg_data
);
	import ssgh_pkg::*;

	typedef enum logic [1:0] {
		STAGE_SEEK    = 2'd0,
		STAGE_BACKOFF = 2'd1,
		STAGE_SLOW    = 2'd2
	} stage_t;

	localparam int CW = COUNT_WIDTH;
	localparam int LW = PosWidth + 2;
	localparam logic [CW-1:0] CountMax = {CW{1'b1}};
	localparam logic [LW-1:0] Margin = LW'(LIMIT_MARGIN);

	logic [RegWidth-1:0] max_pos_q, fast_ivl_q, slow_ivl_q, backoff_q;
	logic [PosWidth-1:0] pos_q, org_q;
	logic [CW-1:0]       left_q, ivl_q, el_q;
	logic                mdir_q, pin_q, dpin_q, ovr_q, busy_q;
	status_t             st_q;
	stage_t              stage_q;

	logic [PosWidth-1:0] pos_n, org_n;
	logic [CW-1:0]       left_n, ivl_n, el_n;
	logic                mdir_n, pin_n, dpin_n, ovr_n, busy_n;
	status_t             st_n;
	stage_t              stage_n;
	logic                stepped;

	logic                ld_en, ld_dir, try_en, over, allowed;
	logic [CW-1:0]       ld_steps, ld_ivl;
	logic signed [LW-1:0] pos_x, n_x, upper_x;

	logic                    accept;
	logic                    out_valid_q;
	logic [OutDataWidth-1:0] out_data_s1;

	kind_t                   kind;
	logic [RegWidth-1:0]     in_steps, in_ivl;
	logic                    in_dir, in_limit, in_ovr;

	assign kind     = kind_t'(s_axis_tuser);
	assign in_steps = s_axis_tdata[23:0];
	assign in_dir   = s_axis_tdata[24];
	assign in_ivl   = s_axis_tdata[48:25];
	assign in_limit = s_axis_tdata[49];
	assign in_ovr   = s_axis_tdata[50];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign pos_x   = $signed({{2{pos_q[PosWidth-1]}}, pos_q});
	assign n_x     = $signed(LW'(ld_steps));
	assign upper_x = $signed(LW'(max_pos_q) - Margin);
	assign over    = ld_dir ? (pos_x + n_x > upper_x) : (pos_x - n_x < $signed(Margin));

	always_comb begin
		pos_n   = pos_q;
		org_n   = org_q;
		left_n  = left_q;
		ivl_n   = ivl_q;
		el_n    = el_q;
		mdir_n  = mdir_q;
		pin_n   = pin_q;
		dpin_n  = dpin_q;
		ovr_n   = ovr_q;
		busy_n  = busy_q;
		st_n    = st_q;
		stage_n = stage_q;
		stepped = 1'b0;
		ld_en    = 1'b0;
		ld_dir   = 1'b0;
		ld_steps = CW'(in_steps);
		ld_ivl   = CW'(in_ivl);
		try_en   = 1'b0;
		allowed  = 1'b0;

		case (kind)
			KIND_TICK: begin
				if (el_q != CountMax)
					el_n = el_q + 1'b1;
				if (busy_q) begin
					ld_steps = CW'(HomingChunk);
					case (stage_q)
						STAGE_SEEK: begin
							if (in_limit) begin
								stage_n = STAGE_BACKOFF;
								pos_n = '0;
								left_n = '0;
								mdir_n = 1'b0;
								ivl_n = '0;
							end else begin
								ld_en  = 1'b1;
								ld_dir = 1'b0;
								ld_ivl = CW'(fast_ivl_q);
								try_en = 1'b1;
							end
						end
						STAGE_BACKOFF: begin
							if ($signed(pos_q) > $signed({1'b0, backoff_q})) begin
								stage_n = STAGE_SLOW;
							end else begin
								ld_en  = 1'b1;
								ld_dir = 1'b1;
								ld_ivl = CW'(fast_ivl_q);
								try_en = 1'b1;
							end
						end
						default: begin
							if (in_limit) begin
								pos_n = '0;
								left_n = '0;
								mdir_n = 1'b0;
								ivl_n = '0;
								ovr_n = 1'b0;
								stage_n = STAGE_SEEK;
								busy_n = 1'b0;
								st_n = ST_READY;
							end else begin
								ld_en  = 1'b1;
								ld_dir = 1'b0;
								ld_ivl = CW'(slow_ivl_q);
								try_en = 1'b1;
							end
						end
					endcase
				end else begin
					try_en = 1'b1;
				end
			end
			KIND_MOVE: begin
				if (!busy_q) begin
					ld_en  = 1'b1;
					ld_dir = in_dir;
				end
			end
			KIND_STOP: begin
				if (!busy_q) begin
					left_n = '0;
					mdir_n = 1'b0;
					ivl_n = '0;
				end
			end
			KIND_HOME: begin
				if (!busy_q) begin
					busy_n = 1'b1;
					stage_n = STAGE_SEEK;
					ovr_n = 1'b1;
					st_n = ST_HOMING;
				end
			end
			KIND_OVERRIDE: begin
				if (!busy_q)
					ovr_n = in_ovr;
			end
			KIND_ORIGIN: begin
				if (!busy_q)
					org_n = pos_q;
			end
			default: begin
			end
		endcase

		if (ld_en) begin
			if (over && !ovr_q) begin
				st_n = ST_OVERLIMIT;
				left_n = '0;
				mdir_n = 1'b0;
				ivl_n = '0;
			end else begin
				left_n = ld_steps;
				mdir_n = ld_dir;
				ivl_n = ld_ivl;
			end
		end

		if (try_en) begin
			if (left_n == '0 && st_n == ST_DRIVING)
				st_n = ST_READY;
			allowed = (st_n != ST_OVERLIMIT) || ovr_n;
			if (el_n > ivl_n && left_n != '0 && allowed) begin
				stepped = 1'b1;
				if (st_n != ST_HOMING)
					st_n = ST_DRIVING;
				dpin_n = mdir_n;
				pin_n = !pin_q;
				el_n = '0;
				pos_n = mdir_n ? pos_n + 1'b1 : pos_n - 1'b1;
				left_n = left_n - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q  <= RegWidth'(10000);
			fast_ivl_q <= RegWidth'(200);
			slow_ivl_q <= RegWidth'(500);
			backoff_q  <= RegWidth'(5000);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_POSITION: max_pos_q  <= cfg_data;
				REG_FAST_IVL:     fast_ivl_q <= cfg_data;
				REG_SLOW_IVL:     slow_ivl_q <= cfg_data;
				REG_BACKOFF:      backoff_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			org_q   <= '0;
			left_q  <= '0;
			ivl_q   <= '0;
			el_q    <= '0;
			mdir_q  <= 1'b0;
			pin_q   <= 1'b0;
			dpin_q  <= 1'b0;
			ovr_q   <= 1'b0;
			busy_q  <= 1'b0;
			st_q    <= ST_READY;
			stage_q <= STAGE_SEEK;
		end else if (accept) begin
			pos_q   <= pos_n;
			org_q   <= org_n;
			left_q  <= left_n;
			ivl_q   <= ivl_n;
			el_q    <= el_n;
			mdir_q  <= mdir_n;
			pin_q   <= pin_n;
			dpin_q  <= dpin_n;
			ovr_q   <= ovr_n;
			busy_q  <= busy_n;
			st_q    <= st_n;
			stage_q <= stage_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_data_s1 <= {3'b000, pos_n - org_n, pos_n, st_n, stepped, dpin_n, pin_n};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_s1;

endmodule

// ===== hdl/ssgh_checker.sv =====
module ssgh_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [ssgh_pkg::OutDataWidth-1:0]  m_axis_tdata
);
	import ssgh_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output register");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted command produced no result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tvalid && s_axis_tready) && m_axis_tready |=> !m_axis_tvalid)
		else $error("result repeated");

endmodule

bind stepper_step_generator_with_homing ssgh_checker u_ssgh_checker (.*);
